// ===== hw/rtl/serial_frame_receiver_macros.svh =====
// ---------------------------------------------------------------------------
// serial_frame_receiver assertion macros
// shared concurrent assertion forms for the receiver
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial_frame_receiver: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial_frame_receiver: next-cycle check failed");

`endif

// ===== hw/rtl/sfr_pkg.sv =====
// ---------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the serial frame receiver
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // frame store depth and its address width
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    // fixed positions inside a frame
    localparam int HDR2_POS = 2;
    localparam int HDR3_POS = 3;
    localparam int LEN_POS  = 4;
    // longest length byte that still fits: 5 header bytes + data + checksum
    localparam int MAX_LEN  = BUF_DEPTH - LEN_POS - 2;

    // register reset values
    localparam logic [7:0]  SYNC_RST    = 8'hFC;
    localparam logic [7:0]  HDR2_RST    = 8'h01;
    localparam logic [7:0]  HDR3_RST    = 8'h30;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        EV_BYTE     = 3'd0,
        EV_CHECKSUM = 3'd1,
        EV_LENGTH   = 3'd2,
        EV_HEADER   = 3'd3,
        EV_TIMEOUT  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        REG_SYNC    = 2'd0,
        REG_HDR2    = 2'd1,
        REG_HDR3    = 2'd2,
        REG_TIMEOUT = 2'd3
    } t_reg_idx;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;      // input transfer this cycle
        logic rd_start;  // prime store read at position zero
        logic load;      // move read data into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic frame_done;  // accepted byte completes a good frame
        logic out_free;    // output register can take a new result
        logic emit_last;   // read data holds the final frame byte
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/sfr_ctrl.sv =====
// ---------------------------------------------------------------------------
// sfr_ctrl
// sequencer: input acceptance and frame replay control
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl
    import sfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_sts.out_free && i_sts.frame_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd.take     = 1'b0;
        o_cmd.rd_start = 1'b0;
        o_cmd.load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = i_sts.out_free;
                o_cmd.take = i_s_tvalid && i_sts.out_free;
            end
            ST_READ: begin
                o_cmd.rd_start = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.load = i_sts.out_free;
            end
            default: o_s_tready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_datapath.sv =====
// ---------------------------------------------------------------------------
// sfr_datapath
// registers, frame store, frame checks and output register
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_datapath
    import sfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_m_tready,
    output logic             o_m_tvalid,
    output logic [2:0]       o_event,
    output logic [7:0]       o_byte,
    output logic [5:0]       o_index,
    output logic             o_last
);

    // configuration
    logic [7:0]  r_sync;
    logic [7:0]  r_hdr2;
    logic [7:0]  r_hdr3;
    logic [15:0] r_timeout;

    // frame state
    logic [ADDR_W-1:0] r_fill,   n_fill;
    logic [7:0]        r_sum,    n_sum;
    logic [15:0]       r_idle,   n_idle;
    logic [ADDR_W-1:0] r_len_m1, n_len_m1;

    // store and replay
    logic [7:0]        r_mem [BUF_DEPTH];
    logic [7:0]        r_rdata;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic              wr_en;

    // output register
    logic        r_out_valid;
    t_event      r_out_event;
    logic [7:0]  r_out_byte;
    logic [5:0]  r_out_index;
    logic        r_out_last;

    logic        fail;
    t_event      fail_ev;
    logic        done;
    logic [15:0] idle_inc;
    logic        emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SYNC_RST;
            r_hdr2    <= HDR2_RST;
            r_hdr3    <= HDR3_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SYNC:    r_sync    <= i_cfg_data[7:0];
                REG_HDR2:    r_hdr2    <= i_cfg_data[7:0];
                REG_HDR3:    r_hdr3    <= i_cfg_data[7:0];
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                default:     r_sync    <= r_sync;
            endcase
        end
    end

    assign idle_inc  = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign emit_last = (r_rd_idx == r_len_m1);

    // per-item checks
    always_comb begin
        fail     = 1'b0;
        fail_ev  = EV_BYTE;
        done     = 1'b0;
        wr_en    = 1'b0;
        n_fill   = r_fill;
        n_sum    = r_sum;
        n_idle   = r_idle;
        n_len_m1 = r_len_m1;
        if (i_cmd.take) begin
            if (t_req'(i_req_type) == REQ_BYTE) begin
                n_idle = '0;
                if (r_fill != '0 || i_rx_byte == r_sync) begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + ADDR_W'(1);
                    n_sum  = r_sum + i_rx_byte;
                    priority if (r_fill == ADDR_W'(HDR2_POS)) begin
                        if (i_rx_byte != r_hdr2) begin
                            fail    = 1'b1;
                            fail_ev = EV_HEADER;
                        end
                    end else if (r_fill == ADDR_W'(HDR3_POS)) begin
                        if (i_rx_byte != r_hdr3) begin
                            fail    = 1'b1;
                            fail_ev = EV_HEADER;
                        end
                    end else if (r_fill == ADDR_W'(LEN_POS)) begin
                        if (i_rx_byte > 8'(MAX_LEN)) begin
                            fail    = 1'b1;
                            fail_ev = EV_LENGTH;
                        end else begin
                            // position of the checksum byte
                            n_len_m1 = ADDR_W'(i_rx_byte + 8'(LEN_POS + 1));
                        end
                    end else if (r_fill > ADDR_W'(LEN_POS) && r_fill == r_len_m1) begin
                        if (i_rx_byte != (r_sync - r_sum)) begin
                            fail    = 1'b1;
                            fail_ev = EV_CHECKSUM;
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        fail = 1'b0;
                    end
                end
            end else begin
                n_idle = idle_inc;
                if (r_fill != '0 && idle_inc > r_timeout) begin
                    fail    = 1'b1;
                    fail_ev = EV_TIMEOUT;
                end
            end
            if (fail || done) begin
                n_fill = '0;
                n_sum  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
            r_idle <= '0;
        end else begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
            r_idle <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_m1 <= n_len_m1;
    end

    // frame store: one write port, one registered read port
    assign rd_en   = i_cmd.rd_start || (i_cmd.load && !emit_last);
    assign rd_addr = i_cmd.rd_start ? '0 : r_rd_idx + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fail || i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fail) begin
            r_out_event <= fail_ev;
            r_out_byte  <= '0;
            r_out_index <= '0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.load) begin
            r_out_event <= EV_BYTE;
            r_out_byte  <= r_rdata;
            r_out_index <= 6'(r_rd_idx);
            r_out_last  <= emit_last;
        end
    end

    assign o_sts.frame_done = done;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;
    assign o_sts.emit_last  = emit_last;

    assign o_m_tvalid = r_out_valid;
    assign o_event    = r_out_event;
    assign o_byte     = r_out_byte;
    assign o_index    = r_out_index;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// serial_frame_receiver
// framed serial byte receiver with sync, header, length and checksum checks
// ---------------------------------------------------------------------------
// Each input transfer is either one received byte (tuser 0) or one idle
// tick (tuser 1). While no frame is open, bytes other than the sync value
// are skipped without a result. A sync byte opens a frame; bytes two and
// three must match the header registers (a bad byte is dropped, not taken
// as a new sync), byte four is the length L, and the frame holds 6 + L
// bytes, the last being (sync - sum of earlier bytes) mod 256. Frames that
// do not fit the 64-byte store are rejected when byte four arrives. A good
// frame is replayed byte by byte with tlast on its final byte; every
// failure gives one event transfer with tlast set. Ticks past idle_timeout
// drop an open frame. While no frame is being replayed, the input is taken
// whenever the output register is empty or being drained. After the byte
// that completes a good frame, tready stays low while the store's
// registered read port is primed and then while the frame is replayed
// byte by byte from that single port. The user must write configuration
// through the cfg channel only while the block is idle; the block does
// not enforce this itself.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_macros.svh"

module serial_frame_receiver
    import sfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  i_s_tuser,   // [0] req_type
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] out_byte, [13:8] byte_index, [15:14] zero
    output logic [2:0]       o_m_tuser,   // [2:0] event_res
    output logic             o_m_tlast,
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd       cmd;
    t_sts       sts;
    logic [2:0] out_event;
    logic [7:0] out_byte;
    logic [5:0] out_index;

    // sequencer
    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // checks, store and output register
    sfr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_s_tuser[0]),
        .i_rx_byte   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_event     (out_event),
        .o_byte      (out_byte),
        .o_index     (out_index),
        .o_last      (o_m_tlast)
    );

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    assign o_m_tdata = {2'b00, out_index, out_byte};
    assign o_m_tuser = out_event;

    // an event result always closes its input
    `SFR_ASSERT_SAME(a_event_is_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != EV_BYTE), o_m_tlast)
    // replay keeps going once a non-final byte is taken
    `SFR_ASSERT_NEXT(a_replay_continues, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid)
    // no input is taken while a frame is being replayed
    `SFR_ASSERT_SAME(a_no_input_in_replay, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, !o_s_tready)

endmodule

`default_nettype wire
